[sv/udpst_pkg.sv]
// Shared codes for the UDP session table: opcodes of an input item and
// status codes of a result item. No dependencies.
package udpst_pkg;

    // Opcodes carried in the input tuser.
    localparam logic [1:0] OPCODE_CLIENT = 2'd0;
    localparam logic [1:0] OPCODE_REPLY  = 2'd1;
    localparam logic [1:0] OPCODE_TICK   = 2'd2;

    // Status codes carried in the output tuser.
    localparam logic [2:0] STATUS_HIT    = 3'd0;
    localparam logic [2:0] STATUS_INSERT = 3'd1;
    localparam logic [2:0] STATUS_FULL   = 3'd2;
    localparam logic [2:0] STATUS_REPLY  = 3'd3;
    localparam logic [2:0] STATUS_IDLE   = 3'd4;

endpackage

[sv/udp_session_table_with_idle_aging_top.sv]
// One entry-walking sequencer serves all items over table memories with one read and one write
// port: it reads one entry per cycle for the lookup pass and one per cycle for the aging sweep.
// The next item is taken only after the result is registered, and a result still waiting at the
// output holds the sequencer in S_DONE and so holds back the next item.
// Reset (rst_n, async, low) clears all valid bits, the sequencer and the output, and sets
// idle_timeout to 60.
// Session table with idle aging; uses udpst_pkg for opcode and status codes.
// Key and last-seen memories live here, valid bits are flip-flops.
module udp_session_table_with_idle_aging_top #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration: idle_timeout
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    // Input items
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata, from bit 0: client_address[31:0], client_port[15:0], reply_slot[3:0],
    // now_seconds[31:0], zero fill[3:0]
    input  logic [87:0] s_tdata,
    // s_tuser: opcode[1:0]
    input  logic [1:0]  s_tuser,
    // Result items
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata, from bit 0: slot[3:0], dest_address[31:0], dest_port[15:0], purged_any,
    // zero fill[2:0]
    output logic [55:0] m_tdata,
    // m_tuser: status[2:0]
    output logic [2:0]  m_tuser
);

    localparam int SLOT_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(TABLE_ENTRIES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_REFRESH,
        S_REPLY,
        S_REPLY_WR,
        S_SWEEP,
        S_INSERT,
        S_DONE
    } state_t;

    // Table memories: key is {address, port}.
    logic [47:0] mem_key  [TABLE_ENTRIES];
    logic [31:0] mem_seen [TABLE_ENTRIES];
    logic [47:0] key_rd_reg;
    logic [31:0] seen_rd_reg;

    logic [SLOT_W-1:0] rd_idx;
    logic [SLOT_W-1:0] wr_idx;
    logic              key_we;
    logic              seen_we;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              pend_reg, pend_next;
    logic [SLOT_W-1:0] pend_idx_reg, pend_idx_next;
    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;
    logic [15:0]       timeout_reg, timeout_next;

    logic [1:0]        op_reg, op_next;
    logic [31:0]       addr_reg, addr_next;
    logic [15:0]       port_reg, port_next;
    logic [3:0]        rslot_reg, rslot_next;
    logic [31:0]       now_reg, now_next;

    logic [SLOT_W-1:0] res_slot_reg, res_slot_next;
    logic [2:0]        res_status_reg, res_status_next;
    logic [31:0]       res_addr_reg, res_addr_next;
    logic [15:0]       res_port_reg, res_port_next;
    logic              purged_reg, purged_next;
    logic              free_found_reg, free_found_next;
    logic [SLOT_W-1:0] free_idx_reg, free_idx_next;

    logic              out_valid_reg, out_valid_next;
    logic [55:0]       out_data_reg, out_data_next;
    logic [2:0]        out_user_reg, out_user_next;

    logic [SLOT_W-1:0] rslot_idx;
    logic              rslot_in_range;
    logic [31:0]       age;
    logic              entry_live;
    logic              entry_expire;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    assign rslot_idx      = SLOT_W'(rslot_reg);
    assign rslot_in_range = ({28'd0, rslot_reg} < 32'(TABLE_ENTRIES));

    // Age of the entry whose last-seen time came out of the memory this cycle.
    assign age          = now_reg - seen_rd_reg;
    assign entry_live   = valid_reg[pend_idx_reg];
    assign entry_expire = entry_live && (timeout_reg != 16'd0) && (age >= {16'd0, timeout_reg});

    // Table memories with registered read data.
    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            mem_key[wr_idx] <= {addr_reg, port_reg};
        end
        if (seen_we)
        begin
            mem_seen[wr_idx] <= now_reg;
        end
        key_rd_reg  <= mem_key[rd_idx];
        seen_rd_reg <= mem_seen[rd_idx];
    end

    // Sequencer: walks the table one entry per cycle for lookup and sweep, and handles replies and inserts.
    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        pend_next       = pend_reg;
        pend_idx_next   = pend_idx_reg;
        valid_next      = valid_reg;
        timeout_next    = timeout_reg;
        op_next         = op_reg;
        addr_next       = addr_reg;
        port_next       = port_reg;
        rslot_next      = rslot_reg;
        now_next        = now_reg;
        res_slot_next   = res_slot_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        res_port_next   = res_port_reg;
        purged_next     = purged_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        out_user_next   = out_user_reg;
        rd_idx          = idx_reg[SLOT_W-1:0];
        wr_idx          = res_slot_reg;
        key_we          = 1'b0;
        seen_we         = 1'b0;

        if (cfg_we)
        begin
            timeout_next = cfg_wdata;
        end

        // The output register drains independently of the sequencer.
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next         = s_tuser;
                    addr_next       = s_tdata[31:0];
                    port_next       = s_tdata[47:32];
                    rslot_next      = s_tdata[51:48];
                    now_next        = s_tdata[83:52];
                    res_slot_next   = '0;
                    res_status_next = udpst_pkg::STATUS_IDLE;
                    res_addr_next   = '0;
                    res_port_next   = '0;
                    purged_next     = 1'b0;
                    free_found_next = 1'b0;
                    idx_next        = '0;
                    pend_next       = 1'b0;
                    if (s_tuser == udpst_pkg::OPCODE_CLIENT)
                    begin
                        state_next = S_LOOK;
                    end
                    else if (s_tuser == udpst_pkg::OPCODE_REPLY)
                    begin
                        state_next = S_REPLY;
                    end
                    else
                    begin
                        state_next = S_SWEEP;
                    end
                end
            end

            S_LOOK:
            begin
                // Compare the entry read last cycle, then issue the next read.
                priority if (pend_reg && entry_live && (key_rd_reg == {addr_reg, port_reg}))
                begin
                    res_slot_next   = pend_idx_reg;
                    res_status_next = udpst_pkg::STATUS_HIT;
                    res_addr_next   = addr_reg;
                    res_port_next   = port_reg;
                    pend_next       = 1'b0;
                    state_next      = S_REFRESH;
                end
                else if (idx_reg == LAST_CNT)
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        idx_next   = '0;
                        state_next = S_SWEEP;
                    end
                end
                else
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = idx_reg[SLOT_W-1:0];
                    idx_next      = idx_reg + CNT_W'(1);
                end
            end

            S_REFRESH:
            begin
                seen_we    = 1'b1;
                wr_idx     = res_slot_reg;
                idx_next   = '0;
                pend_next  = 1'b0;
                state_next = S_SWEEP;
            end

            S_REPLY:
            begin
                rd_idx = rslot_idx;
                if (rslot_in_range && valid_reg[rslot_idx])
                begin
                    res_slot_next   = rslot_idx;
                    res_status_next = udpst_pkg::STATUS_REPLY;
                    state_next      = S_REPLY_WR;
                end
                else
                begin
                    state_next = S_SWEEP;
                end
            end

            S_REPLY_WR:
            begin
                res_addr_next = key_rd_reg[47:16];
                res_port_next = key_rd_reg[15:0];
                seen_we       = 1'b1;
                wr_idx        = res_slot_reg;
                idx_next      = '0;
                pend_next     = 1'b0;
                state_next    = S_SWEEP;
            end

            S_SWEEP:
            begin
                // Age check on the entry read last cycle; also note the lowest free slot.
                if (pend_reg)
                begin
                    if (entry_expire)
                    begin
                        valid_next[pend_idx_reg] = 1'b0;
                        purged_next              = 1'b1;
                    end
                    if ((!entry_live || entry_expire) && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = pend_idx_reg;
                    end
                end
                if (idx_reg == LAST_CNT)
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        if ((op_reg == udpst_pkg::OPCODE_CLIENT) &&
                            (res_status_reg != udpst_pkg::STATUS_HIT))
                        begin
                            if (free_found_reg)
                            begin
                                state_next = S_INSERT;
                            end
                            else
                            begin
                                res_status_next = udpst_pkg::STATUS_FULL;
                                state_next      = S_DONE;
                            end
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                end
                else
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = idx_reg[SLOT_W-1:0];
                    idx_next      = idx_reg + CNT_W'(1);
                end
            end

            S_INSERT:
            begin
                key_we                   = 1'b1;
                seen_we                  = 1'b1;
                wr_idx                   = free_idx_reg;
                valid_next[free_idx_reg] = 1'b1;
                res_slot_next            = free_idx_reg;
                res_status_next          = udpst_pkg::STATUS_INSERT;
                res_addr_next            = addr_reg;
                res_port_next            = port_reg;
                state_next               = S_DONE;
            end

            S_DONE:
            begin
                // Hand the result to the output register once it is free.
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {3'd0, purged_reg, res_port_reg, res_addr_reg,
                                      4'(res_slot_reg)};
                    out_user_next  = res_status_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, valid bits, configuration and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            valid_reg     <= '0;
            timeout_reg   <= 16'd60;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_user_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            valid_reg     <= valid_next;
            timeout_reg   <= timeout_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
            out_user_reg  <= out_user_next;
        end
    end

    // Item payload and working results need no reset.
    always_ff @(posedge clk)
    begin
        pend_idx_reg   <= pend_idx_next;
        op_reg         <= op_next;
        addr_reg       <= addr_next;
        port_reg       <= port_next;
        rslot_reg      <= rslot_next;
        now_reg        <= now_next;
        res_slot_reg   <= res_slot_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        res_port_reg   <= res_port_next;
        purged_reg     <= purged_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
    end

endmodule

[sv/udpst_checker.sv]
// Port-level checks for the UDP session table, bound to the top level.
// Uses udpst_pkg for status codes.
module udpst_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic [2:0]  m_tuser
);

    // The block works on one item at a time, so it is busy right after an accept.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while an item is in work");

    // Only defined status codes leave the block.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser <= udpst_pkg::STATUS_IDLE))
        else $error("undefined status code on output");

    // A dropped packet reports no slot and no destination.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == udpst_pkg::STATUS_FULL)) |-> (m_tdata[51:0] == 52'd0))
        else $error("table-full result carries slot or destination");

    // A tick or an idle reply reports no slot and no destination.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == udpst_pkg::STATUS_IDLE)) |-> (m_tdata[51:0] == 52'd0))
        else $error("idle result carries slot or destination");

    // A stalled result holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind udp_session_table_with_idle_aging_top udpst_checker u_udpst_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
